/* src/urlpd_pkg.sv */
// shared types, character constants and helper functions for the url percent decoder
package urlpd_pkg;

   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [3:0] HEX_ALPHA_OFFSET = 4'd9;

   // escape tracking state
   typedef enum logic [1:0] {
      PEND_NONE  = 2'd0,
      PEND_PCT   = 2'd1,
      PEND_DIGIT = 2'd2
   } pend_state_type;

   // one queue entry: one or two result words
   typedef struct packed {
      logic       two;
      logic [7:0] char0;
      logic       present0;
      logic [7:0] char1;
      logic       last;
   } entry_type;

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [3:0] v;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         v = c[3:0];
      end else if ((c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) ||
                   (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F)) begin
         v = c[3:0] + HEX_ALPHA_OFFSET;
      end else begin
         v = 4'd0;
      end
      return v;
   endfunction

   function automatic logic [7:0] plus_to_space(input logic [7:0] c);
      return (c == CHAR_PLUS) ? CHAR_SPACE : c;
   endfunction

endpackage

/* src/urlpd_if.sv */
// request and response channel interfaces
interface urlpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       in_last;

   modport source (output valid, output in_char, output in_last, input ready);
   modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

interface urlpd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       byte_present;
   logic       out_last;

   modport source (output valid, output out_char, output byte_present, output out_last,
                   input ready);
   modport sink   (input valid, input out_char, input byte_present, input out_last,
                   output ready);
endinterface

/* src/urlpd_front.sv */
// front end: escape tracking and classification of each input word into a queue entry
module urlpd_front
   import urlpd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   urlpd_req_if.sink      req,
   input  logic           queue_full,
   output logic           push,
   output entry_type      push_entry
);

   pend_state_type state_ff, state_in;
   logic [7:0]     first_digit_ff, first_digit_in;
   logic           accept;
   logic [7:0]     decoded;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;
   assign decoded   = {hex_value(first_digit_ff), hex_value(req.in_char)};

   // next state
   always_comb begin
      state_in       = state_ff;
      first_digit_in = first_digit_ff;
      if (accept) begin
         unique case (state_ff)
            PEND_PCT: begin
               if (req.in_last) begin
                  state_in = PEND_NONE;
               end else begin
                  state_in       = PEND_DIGIT;
                  first_digit_in = req.in_char;
               end
            end
            PEND_DIGIT: begin
               state_in = PEND_NONE;
            end
            default: begin
               state_in = (req.in_char == CHAR_PERCENT && !req.in_last) ? PEND_PCT : PEND_NONE;
            end
         endcase
         if (req.in_last) begin
            first_digit_in = 8'd0;
         end
      end
   end

   // outputs
   always_comb begin
      push                = 1'b0;
      push_entry.two      = 1'b0;
      push_entry.char0    = plus_to_space(req.in_char);
      push_entry.present0 = 1'b1;
      push_entry.char1    = plus_to_space(req.in_char);
      push_entry.last     = req.in_last;
      unique case (state_ff)
         PEND_PCT: begin
            // escape cut off: literal percent, then the final word
            push             = accept && req.in_last;
            push_entry.two   = 1'b1;
            push_entry.char0 = CHAR_PERCENT;
         end
         PEND_DIGIT: begin
            push_entry.char0    = decoded;
            push_entry.present0 = (decoded != 8'd0);
            // zero escape is dropped unless it carries the end marker
            push                = accept && ((decoded != 8'd0) || req.in_last);
         end
         default: begin
            push = accept && !(req.in_char == CHAR_PERCENT && !req.in_last);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= PEND_NONE;
         first_digit_ff <= 8'd0;
      end else begin
         state_ff       <= state_in;
         first_digit_ff <= first_digit_in;
      end
   end

endmodule

/* src/urlpd_queue.sv */
// small first-in first-out queue between the front and back ends
module urlpd_queue
   import urlpd_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output logic      head_valid,
   output entry_type head_entry,
   output logic      full
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   entry_type     slot_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == FULL_COUNT);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* src/urlpd_back.sv */
// back end: expands queue entries into response words through an output register
module urlpd_back
   import urlpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  entry_type  head_entry,
   output logic       pop,
   urlpd_rsp_if.source rsp
);

   logic       valid_ff, valid_in;
   logic       second_ff, second_in;
   logic [7:0] char_ff, char_in;
   logic       present_ff, present_in;
   logic       last_ff, last_in;
   logic       load;

   assign load = head_valid && (!valid_ff || rsp.ready);

   always_comb begin
      pop        = 1'b0;
      second_in  = second_ff;
      char_in    = char_ff;
      present_in = present_ff;
      last_in    = last_ff;
      valid_in   = valid_ff && !rsp.ready;
      if (load) begin
         valid_in = 1'b1;
         priority if (head_entry.two && !second_ff) begin
            char_in    = head_entry.char0;
            present_in = 1'b1;
            last_in    = 1'b0;
            second_in  = 1'b1;
         end else if (head_entry.two) begin
            char_in    = head_entry.char1;
            present_in = 1'b1;
            last_in    = head_entry.last;
            second_in  = 1'b0;
            pop        = 1'b1;
         end else begin
            char_in    = head_entry.present0 ? head_entry.char0 : 8'd0;
            present_in = head_entry.present0;
            last_in    = head_entry.last;
            pop        = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
      char_ff    <= char_in;
      present_ff <= present_in;
      last_ff    <= last_in;
   end

   assign rsp.valid        = valid_ff;
   assign rsp.out_char     = char_ff;
   assign rsp.byte_present = present_ff;
   assign rsp.out_last     = last_ff;

endmodule

/* src/url_percent_decoder.sv */
// url percent decoder top level: front end, entry queue and back end
// path: an accepted word is written into the queue, then loaded into the output register that drives rsp
// throughput: one input word per cycle while the queue is not full; an escape cut
//   off by end of string yields two response words from one queue entry
// reset: synchronous active high, clears escape state, queue and output register
module url_percent_decoder
   import urlpd_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   urlpd_req_if.sink    req,
   urlpd_rsp_if.source  rsp
);

   // front to queue
   logic      push;
   entry_type push_entry;
   logic      queue_full;

   // queue to back
   logic      pop;
   logic      head_valid;
   entry_type head_entry;

   // front end tracks '%' escapes and turns each word into zero or one queue entry;
   // it stalls only while the queue is full
   urlpd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // decouples the input side from response back-pressure
   urlpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .full       (queue_full)
   );

   // back end emits one or two response words per entry from its output register
   urlpd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp        (rsp)
   );

endmodule

/* bench/urlpd_checker.sv */
// watches both channels of the percent decoder, predicts decoded words and compares them
`timescale 1ns / 100ps

module urlpd_checker
   import urlpd_pkg::*;
(
   input  logic clock,
   input  logic reset,
   urlpd_req_if req,
   urlpd_rsp_if rsp,
   output int   fail_count,
   output int   outstanding,
   output int   words_checked
);

   typedef struct packed {
      logic [7:0] ch;
      logic       present;
      logic       last;
   } decoded_word_type;

   decoded_word_type decoded_words[$];
   pend_state_type   escape_state;
   logic [7:0]       held_digit;
   int               fails;
   int               checked;

   function automatic logic [3:0] digit_value(input logic [7:0] c);
      logic [7:0] folded;
      folded = c | 8'h20;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) return 4'(c - CHAR_ZERO);
      if (folded >= CHAR_LOWER_A && folded <= CHAR_LOWER_F)
         return 4'(folded - CHAR_LOWER_A + 8'd10);
      return 4'd0;
   endfunction

   function automatic logic [7:0] literal_char(input logic [7:0] c);
      return (c == CHAR_PLUS) ? CHAR_SPACE : c;
   endfunction

   task automatic queue_word(input logic [7:0] ch, input logic present, input logic last);
      decoded_word_type w;
      w.ch      = present ? ch : 8'h00;
      w.present = present;
      w.last    = last;
      decoded_words.push_back(w);
   endtask

   // one raw byte through the escape tracker
   task automatic decode_byte(input logic [7:0] c, input logic last);
      logic [7:0] value;
      case (escape_state)
         PEND_PCT: begin
            if (last) begin
               queue_word(CHAR_PERCENT, 1'b1, 1'b0);
               queue_word(literal_char(c), 1'b1, 1'b1);
               escape_state = PEND_NONE;
            end else begin
               held_digit   = c;
               escape_state = PEND_DIGIT;
            end
         end
         PEND_DIGIT: begin
            value = {digit_value(held_digit), digit_value(c)};
            if (value != 8'h00) queue_word(value, 1'b1, last);
            else if (last) queue_word(8'h00, 1'b0, 1'b1);
            escape_state = PEND_NONE;
         end
         default: begin
            if (c == CHAR_PERCENT && !last) begin
               escape_state = PEND_PCT;
            end else begin
               queue_word(literal_char(c), 1'b1, last);
               escape_state = PEND_NONE;
            end
         end
      endcase
      if (last) begin
         escape_state = PEND_NONE;
         held_digit   = 8'h00;
      end
   endtask

   task automatic compare_word();
      decoded_word_type want;
      if (decoded_words.size() == 0) begin
         $error("unexpected word: out_char %h byte_present %b out_last %b",
                rsp.out_char, rsp.byte_present, rsp.out_last);
         fails++;
      end else begin
         want = decoded_words.pop_front();
         checked++;
         if (rsp.out_char !== want.ch) begin
            $error("out_char: expected %h, actual %h", want.ch, rsp.out_char);
            fails++;
         end
         if (rsp.byte_present !== want.present) begin
            $error("byte_present: expected %b, actual %b", want.present, rsp.byte_present);
            fails++;
         end
         if (rsp.out_last !== want.last) begin
            $error("out_last: expected %b, actual %b", want.last, rsp.out_last);
            fails++;
         end
      end
   endtask

   initial begin
      fails   = 0;
      checked = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         escape_state = PEND_NONE;
         held_digit   = 8'h00;
         decoded_words.delete();
      end else begin
         if (req.valid && req.ready) decode_byte(req.in_char, req.in_last);
         if (rsp.valid && rsp.ready) compare_word();
      end
      fail_count    <= fails;
      outstanding   <= decoded_words.size();
      words_checked <= checked;
   end

endmodule

/* bench/tb.sv */
// top of the percent decoder bench: clock, reset, stimulus, receiver and verdict
`timescale 1ns / 100ps

module tb
   import urlpd_pkg::*;
();

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_BYTES = 370;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_CYCLES  = 60;

   logic clock;
   logic reset = 1'b1;

   int fail_count;
   int outstanding;
   int words_checked;
   int cycle_count = 0;
   int bytes_sent = 0;
   int strings_sent = 0;
   int taken_words = 0;
   bit no_idle = 1'b0;
   bit rsp_burst = 1'b0;

   urlpd_req_if req_ch ();
   urlpd_rsp_if rsp_ch ();

   url_percent_decoder dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   urlpd_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req           (req_ch),
      .rsp           (rsp_ch),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .words_checked (words_checked)
   );

   // 12 ns period
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // hard stop in case the handshake locks up
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // offer one raw byte and hold it until the decoder takes it
   task automatic send_word(input logic [7:0] c, input logic last);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.in_char <= c;
      req_ch.in_last <= last;
      do @(posedge clock); while (!req_ch.ready);
      bytes_sent++;
   endtask

   task automatic send_string(input string s);
      int k;
      for (k = 0; k < s.len(); k++) send_word(s[k], k == s.len() - 1);
      strings_sent++;
   endtask

   // hex digit in mixed case, '0' drawn more often so zero escapes show up
   function automatic logic [7:0] random_hex();
      int v;
      v = $urandom_range(0, 19);
      if (v >= 16) v = 0;
      if (v < 10) return 8'(CHAR_ZERO + v);
      if ($urandom_range(0, 1) == 1) return 8'(CHAR_UPPER_A + v - 10);
      return 8'(CHAR_LOWER_A + v - 10);
   endfunction

   // mostly well formed escapes and plain text, some broken or cut off escapes
   task automatic send_random_string();
      logic [7:0] text[$];
      int         pieces;
      int         kind;
      int         k;
      pieces = $urandom_range(1, 6);
      for (k = 0; k < pieces; k++) begin
         kind = $urandom_range(0, 19);
         if (kind < 8) begin
            text.push_back(8'($urandom_range(0, 255)));
         end else if (kind < 10) begin
            text.push_back(CHAR_PLUS);
         end else if (kind < 16) begin
            text.push_back(CHAR_PERCENT);
            text.push_back(random_hex());
            text.push_back(random_hex());
         end else if (kind < 18) begin
            // escape with arbitrary digit bytes
            text.push_back(CHAR_PERCENT);
            text.push_back(8'($urandom_range(0, 255)));
            text.push_back(8'($urandom_range(0, 255)));
         end else if (kind == 18) begin
            text.push_back(CHAR_PERCENT);
         end else begin
            text.push_back(CHAR_PERCENT);
            text.push_back(random_hex());
         end
      end
      no_idle = ($urandom_range(0, 3) == 0);
      for (k = 0; k < text.size(); k++) send_word(text[k], k == text.size() - 1);
      strings_sent++;
   endtask

   // receiver: random stalls, burst stretches, and two long hold-offs
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (taken_words == 40 || taken_words == 220) stall = HOLD_CYCLES;
         else if (rsp_burst) stall = 0;
         else stall = $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         taken_words++;
         if (taken_words % 24 == 0) rsp_burst = ($urandom_range(0, 3) == 0);
      end
   end

   // sender and verdict
   initial begin
      req_ch.valid   <= 1'b0;
      req_ch.in_char <= 8'h00;
      req_ch.in_last <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // plus mapping, mixed case digits, an escaped plus, max value, non-hex digit
      send_string("+%2B%4a%Ff%z1");
      // zero escape mid string is dropped, then a cut off escape with one digit
      send_string("%0zx%g");
      // zero escape at the end gives a bare end marker
      send_string("%00");
      // lone percent as the whole string
      send_string("%");
      // null and all-ones bytes as data, string ending on a percent
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(CHAR_PERCENT, 1'b1);
      strings_sent++;
      // percent cut off by a final plus
      send_string("%+");

      while (bytes_sent < RANDOM_BYTES) send_random_string();
      req_ch.valid <= 1'b0;

      // let the checker count the words of the final byte before waiting on them
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d encoded bytes in %0d strings, %0d decoded words checked",
               bytes_sent, strings_sent, words_checked);
      $display("receiver held off twice for %0d cycles to back up the input", HOLD_CYCLES);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
